FILE: sv/assert_macros.svh
// Assertion macros used by the top level of the run gate.
// No dependencies; included where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: lbl");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: lbl");

`endif

FILE: sv/mlrg_pkg.sv
// Package of the minimum-length run gate: sizes, register indexes, types.
// No dependencies.
`default_nettype none
package mlrg_pkg;
   localparam int MAX_HOLD   = 32;
   localparam int HOLD_IDX_W = $clog2(MAX_HOLD);
   localparam int CP_W       = 21;
   localparam int MIN_RUN_W  = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 21;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   localparam logic [CSR_ADDR_W-1:0] REG_MIN_RUN       = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_BEFORE_ENABLE = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_BEFORE_CODE   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_AFTER_ENABLE  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_AFTER_CODE    = 3'd4;

   typedef struct packed {
      logic push;
      logic pull;
      logic clear;
   } chain_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BEFORE,
      ST_DRAIN,
      ST_AFTER
   } gate_state_type;
endpackage
`default_nettype wire

FILE: sv/mlrg_cell.sv
// One hold cell: a code point and a full flag; fills after its left
// neighbor and shifts toward the head on a pull. Depends on mlrg_pkg.
`default_nettype none
module mlrg_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  mlrg_pkg::chain_ctrl_type     ctrl,
   input  wire  [mlrg_pkg::CP_W-1:0]    push_code,
   input  wire                          prev_full,
   input  wire                          next_full,
   input  wire  [mlrg_pkg::CP_W-1:0]    next_code,
   output logic                         full,
   output logic [mlrg_pkg::CP_W-1:0]    code
);
   import mlrg_pkg::*;

   logic            full_ff, full_in;
   logic [CP_W-1:0] code_ff, code_in;

   always_comb begin
      full_in = full_ff;
      code_in = code_ff;
      if (ctrl.clear) begin
         full_in = 1'b0;
      end else if (ctrl.pull) begin
         full_in = next_full;
         code_in = next_code;
      end else if (ctrl.push && prev_full && !full_ff) begin
         full_in = 1'b1;
         code_in = push_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      code_ff <= code_in;
   end

   assign full = full_ff;
   assign code = code_ff;
endmodule
`default_nettype wire

FILE: sv/mlrg_chain.sv
// Row of MAX_HOLD hold cells; fills from the head, drains through the head.
// Depends on mlrg_pkg and mlrg_cell.
`default_nettype none
module mlrg_chain (
   input  wire                               clock,
   input  wire                               reset,
   input  mlrg_pkg::chain_ctrl_type          ctrl,
   input  wire  [mlrg_pkg::CP_W-1:0]         push_code,
   output logic [mlrg_pkg::MAX_HOLD-1:0]     full,
   output logic [mlrg_pkg::CP_W-1:0]         head_code
);
   import mlrg_pkg::*;

   logic [CP_W-1:0] codes [MAX_HOLD];

   for (genvar i = 0; i < MAX_HOLD; i++) begin : g_cell
      logic            prev_full, next_full;
      logic [CP_W-1:0] next_code;

      if (i == 0) begin : g_head
         assign prev_full = 1'b1;
      end else begin : g_body
         assign prev_full = full[i-1];
      end

      if (i == MAX_HOLD - 1) begin : g_tail
         assign next_full = 1'b0;
         assign next_code = '0;
      end else begin : g_inner
         assign next_full = full[i+1];
         assign next_code = codes[i+1];
      end

      mlrg_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .push_code (push_code),
         .prev_full (prev_full),
         .next_full (next_full),
         .next_code (next_code),
         .full      (full[i]),
         .code      (codes[i])
      );
   end

   assign head_code = codes[0];
endmodule
`default_nettype wire

FILE: sv/min_length_run_gate.sv
// Top level of the minimum-length run gate: registers, control, output word.
// Depends on mlrg_pkg, mlrg_chain and assert_macros.svh.
//
//   port group  dir  word contents
//   req_*       in   tdata: code_point; tuser: action, is_match
//   rsp_*       out  tdata: out_code; tuser: is_marker; tlast: last
//   csr_*       in   write enable, register index, data
//
// A word with no burst leaves the gate idle; a qualifying word starts a burst:
// optional before marker, held codes, optional after marker, drained from the
// head of the cell row one result a cycle while rsp is not stalled. Reset is
// synchronous and empties the row. A stalled rsp holds the control in place;
// req is taken only while idle with the output register free.
`default_nettype none
module min_length_run_gate (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [mlrg_pkg::REQ_DATA_W-1:0]    req_tdata,  // code_point
   input  wire  [1:0]                         req_tuser,  // action, is_match
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [mlrg_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // out_code
   output logic                               rsp_tuser,  // is_marker
   output logic                               rsp_tlast,
   input  wire                                csr_we,
   input  wire  [mlrg_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire  [mlrg_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mlrg_pkg::*;
`include "assert_macros.svh"

   logic [MIN_RUN_W-1:0] min_run_ff;
   logic                 before_en_ff, after_en_ff;
   logic [CP_W-1:0]      before_code_ff, after_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_run_ff     <= MIN_RUN_W'(1);
         before_en_ff   <= 1'b0;
         before_code_ff <= '0;
         after_en_ff    <= 1'b1;
         after_code_ff  <= CP_W'(10);
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_MIN_RUN:       min_run_ff     <= csr_wdata[MIN_RUN_W-1:0];
            REG_BEFORE_ENABLE: before_en_ff   <= csr_wdata[0];
            REG_BEFORE_CODE:   before_code_ff <= csr_wdata[CP_W-1:0];
            REG_AFTER_ENABLE:  after_en_ff    <= csr_wdata[0];
            REG_AFTER_CODE:    after_code_ff  <= csr_wdata[CP_W-1:0];
            default: ;
         endcase
      end
   end

   // index of the cell whose fill means the run qualifies
   logic [HOLD_IDX_W-1:0] min_idx;
   always_comb begin
      if (min_run_ff == '0) begin
         min_idx = '0;
      end else if (min_run_ff > MIN_RUN_W'(MAX_HOLD)) begin
         min_idx = HOLD_IDX_W'(MAX_HOLD - 1);
      end else begin
         min_idx = HOLD_IDX_W'(min_run_ff - MIN_RUN_W'(1));
      end
   end

   gate_state_type        state_ff, state_in;
   logic                  streaming_ff, streaming_in;
   logic                  close_ff, close_in;
   chain_ctrl_type        ctrl;
   logic [MAX_HOLD-1:0]   full, push_full;
   logic [CP_W-1:0]       head_code;

   mlrg_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .push_code (req_tdata[CP_W-1:0]),
      .full      (full),
      .head_code (head_code)
   );

   logic            rsp_valid_ff, rsp_valid_in;
   logic [CP_W-1:0] rsp_code_ff;
   logic            rsp_marker_ff, rsp_last_ff;
   logic            can_load, accept, char_match, qualify_push, qualify_close;
   logic            drain_end;
   logic            emit, emit_marker, emit_last;
   logic [CP_W-1:0] emit_code;

   assign can_load      = !rsp_valid_ff || rsp_tready;
   assign req_tready    = (state_ff == ST_IDLE) && can_load;
   assign accept        = req_tvalid && req_tready;
   assign char_match    = !req_tuser[0] && req_tuser[1];
   assign push_full     = full | {full[MAX_HOLD-2:0], 1'b1};
   assign qualify_push  = push_full[min_idx];
   assign qualify_close = full[min_idx];
   assign drain_end     = !full[1];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !streaming_ff &&
                ((char_match && qualify_push) || (!char_match && qualify_close))) begin
               state_in = before_en_ff ? ST_BEFORE : ST_DRAIN;
            end
         end
         ST_BEFORE: begin
            if (can_load) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (can_load && drain_end) begin
               state_in = (close_ff && after_en_ff) ? ST_AFTER : ST_IDLE;
            end
         end
         ST_AFTER: begin
            if (can_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and chain control
   always_comb begin
      emit         = 1'b0;
      emit_code    = '0;
      emit_marker  = 1'b0;
      emit_last    = 1'b0;
      ctrl         = '0;
      streaming_in = streaming_ff;
      close_in     = close_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (char_match) begin
                  if (streaming_ff) begin
                     emit      = 1'b1;
                     emit_code = req_tdata[CP_W-1:0];
                     emit_last = 1'b1;
                  end else begin
                     ctrl.push = 1'b1;
                     if (qualify_push) begin
                        streaming_in = 1'b1;
                        close_in     = 1'b0;
                     end
                  end
               end else begin
                  streaming_in = 1'b0;
                  if (streaming_ff) begin
                     emit        = after_en_ff;
                     emit_code   = after_code_ff;
                     emit_marker = 1'b1;
                     emit_last   = 1'b1;
                  end else if (qualify_close) begin
                     close_in = 1'b1;
                  end else begin
                     ctrl.clear = 1'b1;
                  end
               end
            end
         end
         ST_BEFORE: begin
            emit        = 1'b1;
            emit_code   = before_code_ff;
            emit_marker = 1'b1;
         end
         ST_DRAIN: begin
            emit      = 1'b1;
            emit_code = head_code;
            emit_last = drain_end && !(close_ff && after_en_ff);
            ctrl.pull = can_load;
         end
         ST_AFTER: begin
            emit        = 1'b1;
            emit_code   = after_code_ff;
            emit_marker = 1'b1;
            emit_last   = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      if (emit && can_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         streaming_ff <= 1'b0;
         close_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         streaming_ff <= streaming_in;
         close_ff     <= close_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit && can_load) begin
         rsp_code_ff   <= emit_code;
         rsp_marker_ff <= emit_marker;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_code_ff);
   assign rsp_tuser  = rsp_marker_ff;
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_IMPLIES(a_drain_has_data, clock, reset, state_ff == ST_DRAIN, full[0])
   `ASSERT_IMPLIES(a_stream_row_empty, clock, reset,
                   state_ff == ST_IDLE && streaming_ff, !full[0])
   `ASSERT_NEXT(a_before_to_drain, clock, reset,
                state_ff == ST_BEFORE && can_load, state_ff == ST_DRAIN)
endmodule
`default_nettype wire
